@@ hw/rtl/wto_pkg.sv @@
`timescale 1ns / 1ps

package wto_pkg;

    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths
    localparam int FREQ_BITS  = 24;
    localparam int SOR_BITS   = 32;
    localparam int START_BITS = 16;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    // size_over_rate is Q4.28 and frequency Q16.8: product carries 36 fraction bits
    localparam int PROD_FRAC_BITS = 36;
    localparam int PROD_BITS      = SOR_BITS + 1 + FREQ_BITS;

    localparam logic                INTERP_RESET = 1'b1;
    localparam logic [SOR_BITS-1:0] SOR_RESET    = 32'd5726623;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

    typedef enum logic [CFG_IDX_BITS-1:0]
    {
        REG_INTERPOLATE_MODE = 2'd0,
        REG_SIZE_OVER_RATE   = 2'd1,
        REG_START_PHASE      = 2'd2
    } cfg_reg_t;

endpackage

@@ hw/rtl/wavetable_oscillator_core.sv @@
`timescale 1ns / 1ps

// Wavetable oscillator. Write requests load one table entry; tick requests return one sample
// taken at the current phase (truncated or linearly interpolated, the last entry blending
// toward entry 0) and then advance the phase by frequency * size_over_rate. One request is
// taken every cycle while the output is not stalled. The rate is set by the phase loop, a
// single adder at the table-address stage, and by the table's two registered read ports.
// Writing start_phase reloads the phase. Registers must be written only while no request is
// in flight; the block itself does not enforce this.

module wavetable_oscillator_core #(
    parameter int TABLE_BITS  = wto_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = wto_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [wto_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  logic [wto_pkg::CFG_BITS-1:0]       cfg_wdata,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [TABLE_BITS-1:0]              entry_index,
    input  logic signed [SAMPLE_BITS-1:0]      entry_value,
    input  logic signed [wto_pkg::FREQ_BITS-1:0] frequency,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample
);

    localparam int PH_BITS   = TABLE_BITS + FRAC_BITS;
    localparam int SHIFT     = wto_pkg::PROD_FRAC_BITS - FRAC_BITS;
    localparam int PROD_BITS = wto_pkg::PROD_BITS;
    localparam int T_BITS    = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int SP_BITS   = wto_pkg::START_BITS + 40;

    // configuration
    logic                              interp_reg;
    logic [wto_pkg::SOR_BITS-1:0]      sor_reg;
    logic [PH_BITS-1:0]                phase_reg;
    logic [PH_BITS-1:0]                phase_next;
    logic [SP_BITS-1:0]                start_wide;

    // stage 1: input register
    logic                              v1_reg;
    logic                              cmd1_reg;
    logic [TABLE_BITS-1:0]             idx1_reg;
    logic [SAMPLE_BITS-1:0]            val1_reg;
    logic signed [wto_pkg::FREQ_BITS-1:0] freq1_reg;

    // stage 2: increment product, table access
    logic                              v2_reg;
    logic                              cmd2_reg;
    logic [TABLE_BITS-1:0]             idx2_reg;
    logic [SAMPLE_BITS-1:0]            val2_reg;
    logic signed [PROD_BITS-1:0]       prod2_reg;
    logic signed [PROD_BITS-1:0]       prod_next;

    // stage 3: table data
    logic                              v3_reg;
    logic [FRAC_BITS-1:0]              frac3_reg;
    logic [SAMPLE_BITS-1:0]            a3;
    logic [SAMPLE_BITS-1:0]            b3;
    logic signed [SAMPLE_BITS:0]       diff3;
    logic signed [T_BITS-1:0]          t_next;

    // stage 4: blend product
    logic                              v4_reg;
    logic [SAMPLE_BITS-1:0]            a4_reg;
    logic signed [T_BITS-1:0]          t4_reg;
    logic [SAMPLE_BITS-1:0]            sample_next;

    // output
    logic                              out_valid_reg;
    logic [SAMPLE_BITS-1:0]            sample_reg;

    logic en_out, en4, en3, en2, en1;
    logic tick2, write2;
    logic [TABLE_BITS-1:0] i0, i1;

    assign en_out = !out_valid_reg || out_ready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign in_ready  = en1;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    assign tick2  = v2_reg && (cmd2_reg == wto_pkg::CMD_TICK);
    assign write2 = v2_reg && (cmd2_reg == wto_pkg::CMD_WRITE);

    // start phase aligned to the top of the accumulator
    assign start_wide = {cfg_wdata[wto_pkg::START_BITS-1:0], 40'd0};

    always_comb
    begin
        phase_next = phase_reg + prod2_reg[SHIFT +: PH_BITS];
        prod_next  = $signed({1'b0, sor_reg}) * freq1_reg;
        i0         = phase_reg[PH_BITS-1:FRAC_BITS];
        i1         = i0 + {{(TABLE_BITS-1){1'b0}}, 1'b1};
        diff3      = $signed({b3[SAMPLE_BITS-1], b3}) - $signed({a3[SAMPLE_BITS-1], a3});
        t_next     = diff3 * $signed({1'b0, frac3_reg});
        if (interp_reg)
        begin
            sample_next = a4_reg + t4_reg[FRAC_BITS +: SAMPLE_BITS];
        end
        else
        begin
            sample_next = a4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= wto_pkg::INTERP_RESET;
            sor_reg    <= wto_pkg::SOR_RESET;
            phase_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wto_pkg::REG_INTERPOLATE_MODE: interp_reg <= cfg_wdata[0];
                wto_pkg::REG_SIZE_OVER_RATE:   sor_reg    <= cfg_wdata[wto_pkg::SOR_BITS-1:0];
                wto_pkg::REG_START_PHASE:      phase_reg  <= start_wide[SP_BITS-1 -: PH_BITS];
                default:                       ;
            endcase
        end
        else if (en3 && tick2)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= tick2;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            cmd1_reg  <= command;
            idx1_reg  <= entry_index;
            val1_reg  <= entry_value;
            freq1_reg <= frequency;
        end
        if (en2 && v1_reg)
        begin
            cmd2_reg  <= cmd1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            prod2_reg <= prod_next;
        end
        if (en3 && tick2)
        begin
            frac3_reg <= phase_reg[FRAC_BITS-1:0];
        end
        if (en4 && v3_reg)
        begin
            a4_reg <= a3;
            t4_reg <= t_next;
        end
        if (en_out && v4_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    wto_table #(
        .ADDR_BITS (TABLE_BITS),
        .DATA_BITS (SAMPLE_BITS)
    ) u_table (
        .clk       (clk),
        .wr_en     (en3 && write2),
        .wr_addr   (idx2_reg),
        .wr_data   (val2_reg),
        .rd_en     (en3 && tick2),
        .rd_addr_a (i0),
        .rd_addr_b (i1),
        .rd_data_a (a3),
        .rd_data_b (b3)
    );

endmodule

@@ hw/rtl/wto_table.sv @@
`timescale 1ns / 1ps

module wto_table #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_a_reg;
    logic [DATA_BITS-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int TBITS   = wto_pkg::TABLE_BITS_DEF;
    localparam int SBITS   = wto_pkg::SAMPLE_BITS_DEF;
    localparam int FBITS   = wto_pkg::FRAC_BITS_DEF;
    localparam int PH_BITS = TBITS + FBITS;
    localparam int TBL_LEN = 1 << TBITS;

    localparam int FREQ_BITS      = wto_pkg::FREQ_BITS;
    localparam int CFG_IDX_BITS   = wto_pkg::CFG_IDX_BITS;
    localparam int CFG_BITS       = wto_pkg::CFG_BITS;
    localparam int SOR_BITS       = wto_pkg::SOR_BITS;
    localparam int START_BITS     = wto_pkg::START_BITS;
    localparam int PROD_BITS      = wto_pkg::PROD_BITS;
    localparam int PROD_FRAC_BITS = wto_pkg::PROD_FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [FREQ_BITS-1:0] FREQ_MAX   = 24'sh7F_FFFF;
    localparam logic signed [FREQ_BITS-1:0] FREQ_MIN   = 24'sh80_0000;
    localparam logic signed [FREQ_BITS-1:0] FREQ_ZERO  = 24'sh00_0000;
    localparam logic signed [FREQ_BITS-1:0] FREQ_ONE_HZ = 24'sh00_0100;
    localparam logic signed [FREQ_BITS-1:0] FREQ_NEG_LSB = 24'shFF_FFFF;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int N_PROBES     = 18;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_addr    = '0;
    logic [CFG_BITS-1:0]           cfg_wdata   = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic                          command     = wto_pkg::CMD_WRITE;
    logic [TBITS-1:0]              entry_index = '0;
    logic signed [SBITS-1:0]       entry_value = '0;
    logic signed [FREQ_BITS-1:0]   frequency   = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic signed [SBITS-1:0]       sample;

    wavetable_oscillator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .frequency   (frequency),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // oscillator shadow state
    logic                    interp_on = wto_pkg::INTERP_RESET;
    logic [SOR_BITS-1:0]     ratio     = wto_pkg::SOR_RESET;
    logic [PH_BITS-1:0]      osc_phase = '0;
    logic signed [SBITS-1:0] wave_mem [TBL_LEN];
    bit                      entry_written [TBL_LEN];

    logic signed [SBITS-1:0] pending_samples [$];
    logic signed [SBITS-1:0] want_sample;

    int          err_count    = 0;
    int          src_idle_pct = 38;
    int          snk_idle_pct = 80;
    int          sent_count   = 0;
    int unsigned cycle_count  = 0;

    typedef struct packed
    {
        wto_pkg::command_t           cmd;
        logic [TBITS-1:0]            idx;
        logic signed [SBITS-1:0]     val;
        logic signed [FREQ_BITS-1:0] freq;
        logic                        has_want;
        logic signed [SBITS-1:0]     want;
    } probe_t;

    probe_t probe_rows [N_PROBES] = '{
        '{wto_pkg::CMD_WRITE, 10'd0,    16'sh7FFF, FREQ_NEG_LSB, 1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd1,    16'sh8000, FREQ_MIN,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd1023, 16'sh1234, FREQ_MAX,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd1023, 16'sh8000, FREQ_ZERO,    1'b1, 16'sh7FFF},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh7FFF, FREQ_NEG_LSB, 1'b1, 16'sh7FFF},
        '{wto_pkg::CMD_TICK,  10'd5,    16'sh0000, FREQ_ONE_HZ,  1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, FREQ_ZERO,    1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, FREQ_MIN,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, FREQ_MAX,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd512,  16'sh0001, FREQ_ZERO,    1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd511,  16'shFFFF, FREQ_MAX,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd1023, 16'shFFFF, FREQ_MAX,     1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, 24'sh80_0001, 1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd0,    16'sh8000, FREQ_ZERO,    1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd1,    16'sh7FFF, FREQ_ZERO,    1'b0, 16'sh0000},
        '{wto_pkg::CMD_WRITE, 10'd1023, 16'sh8000, FREQ_ZERO,    1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, 24'sh00_0001, 1'b0, 16'sh0000},
        '{wto_pkg::CMD_TICK,  10'd0,    16'sh0000, FREQ_ZERO,    1'b0, 16'sh0000}
    };

    task automatic flag_mismatch(input string msg);
        if (err_count < 100)
            $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // sample at the current phase, before the advance
    function automatic logic signed [SBITS-1:0] tick_sample();
        logic [TBITS-1:0]        lo_idx;
        logic [TBITS-1:0]        hi_idx;
        logic signed [SBITS:0]   lo_val;
        logic signed [SBITS:0]   hi_val;
        logic signed [SBITS:0]   span;
        logic signed [2*SBITS+8:0] blend;
        lo_idx = osc_phase[PH_BITS-1 -: TBITS];
        hi_idx = lo_idx + 1'b1;
        lo_val = wave_mem[lo_idx];
        hi_val = wave_mem[hi_idx];
        if (!interp_on)
            return wave_mem[lo_idx];
        span  = hi_val - lo_val;
        blend = span * $signed({1'b0, osc_phase[FBITS-1:0]});
        blend = lo_val + (blend >>> FBITS);
        return blend[SBITS-1:0];
    endfunction

    task automatic advance_phase(input logic signed [FREQ_BITS-1:0] freq);
        logic signed [SOR_BITS:0]    ratio_s;
        logic signed [PROD_BITS-1:0] prod;
        ratio_s   = {1'b0, ratio};
        prod      = ratio_s * freq;
        osc_phase = osc_phase + prod[PROD_FRAC_BITS-FBITS +: PH_BITS];
    endtask

    task automatic push_request(input wto_pkg::command_t cmd, input logic [TBITS-1:0] idx,
                                input logic signed [SBITS-1:0] val,
                                input logic signed [FREQ_BITS-1:0] freq,
                                input bit has_want, input logic signed [SBITS-1:0] want);
        logic signed [SBITS-1:0] predicted;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= val;
        frequency   <= freq;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        if (cmd == wto_pkg::CMD_WRITE)
        begin
            wave_mem[idx]      = val;
            entry_written[idx] = 1'b1;
        end
        else
        begin
            predicted = tick_sample();
            advance_phase(freq);
            pending_samples.push_back(has_want ? want : predicted);
        end
    endtask

    // a tick may only read entries already loaded
    task automatic fill_read_entries();
        logic [TBITS-1:0] lo_idx;
        lo_idx = osc_phase[PH_BITS-1 -: TBITS];
        if (!entry_written[lo_idx])
            push_request(wto_pkg::CMD_WRITE, lo_idx, SBITS'($urandom), FREQ_BITS'($urandom),
                         1'b0, '0);
        lo_idx = lo_idx + 1'b1;
        if (!entry_written[lo_idx])
            push_request(wto_pkg::CMD_WRITE, lo_idx, SBITS'($urandom), FREQ_BITS'($urandom),
                         1'b0, '0);
    endtask

    task automatic settle_phase();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] addr, input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (addr)
            wto_pkg::REG_INTERPOLATE_MODE: interp_on = data[0];
            wto_pkg::REG_SIZE_OVER_RATE:   ratio     = data[SOR_BITS-1:0];
            wto_pkg::REG_START_PHASE:
                osc_phase = {data[START_BITS-1:0], {(PH_BITS-START_BITS){1'b0}}};
            default: ;
        endcase
    endtask

    function automatic logic signed [FREQ_BITS-1:0] pick_frequency();
        logic signed [FREQ_BITS-1:0] f;
        case ($urandom_range(9))
            0:       f = FREQ_MAX;
            1:       f = FREQ_MIN;
            2:       f = ($urandom_range(1)) ? FREQ_ZERO : FREQ_NEG_LSB;
            3, 4, 5: f = FREQ_BITS'($urandom_range(0, 131071)) - 24'sd65536;
            6:       f = FREQ_BITS'($urandom_range(0, 8191)) - 24'sd4096;
            default: f = FREQ_BITS'($urandom);
        endcase
        return f;
    endfunction

    // count covers every request sent, table fills included
    task automatic run_random(input int count);
        int stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
        begin
            if (sent_count < 175)
            begin
                src_idle_pct = 38;
                snk_idle_pct = 80;
            end
            else if (sent_count < 350)
            begin
                src_idle_pct = 80;
                snk_idle_pct = 38;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(99) < 35)
                push_request(wto_pkg::CMD_WRITE, TBITS'($urandom), SBITS'($urandom),
                             FREQ_BITS'($urandom), 1'b0, '0);
            else
            begin
                fill_read_entries();
                push_request(wto_pkg::CMD_TICK, TBITS'($urandom), SBITS'($urandom),
                             pick_frequency(), 1'b0, '0);
            end
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
                flag_mismatch($sformatf("sample %0d with no tick outstanding", sample));
            else
            begin
                want_sample = pending_samples.pop_front();
                if (sample !== want_sample)
                    flag_mismatch($sformatf("sample %0d, expected %0d", sample, want_sample));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("wavetable_oscillator_core verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (probe_rows[i])
        begin
            if (probe_rows[i].cmd == wto_pkg::CMD_TICK)
                fill_read_entries();
            push_request(probe_rows[i].cmd, probe_rows[i].idx, probe_rows[i].val,
                         probe_rows[i].freq, probe_rows[i].has_want, probe_rows[i].want);
        end
        settle_phase();

        // unmapped index must leave everything alone
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(wto_pkg::REG_INTERPOLATE_MODE, 32'd0);
        write_reg(wto_pkg::REG_START_PHASE, 32'h0000_4000);
        run_random(120);
        settle_phase();

        write_reg(wto_pkg::REG_INTERPOLATE_MODE, 32'd1);
        write_reg(wto_pkg::REG_SIZE_OVER_RATE, 32'hFFFF_FFFF);
        write_reg(wto_pkg::REG_START_PHASE, 32'h0000_FFFF);
        run_random(120);
        settle_phase();

        write_reg(wto_pkg::REG_SIZE_OVER_RATE, 32'd0);
        write_reg(wto_pkg::REG_START_PHASE, 32'd0);
        run_random(40);
        settle_phase();

        write_reg(wto_pkg::REG_INTERPOLATE_MODE, 32'd0);
        write_reg(wto_pkg::REG_SIZE_OVER_RATE, $urandom);
        write_reg(wto_pkg::REG_START_PHASE, $urandom_range(0, 65535));
        run_random(110);
        settle_phase();

        write_reg(wto_pkg::REG_INTERPOLATE_MODE, 32'd1);
        write_reg(wto_pkg::REG_SIZE_OVER_RATE, $urandom_range(0, 32'h0100_0000));
        write_reg(wto_pkg::REG_START_PHASE, $urandom_range(0, 65535));
        run_random(110);
        settle_phase();

        if (err_count == 0)
            $display("wavetable_oscillator_core verification clean");
        else
            $display("wavetable_oscillator_core verification failed");
        $finish;
    end

endmodule
